FILE: hw/rtl/rtc_pkg.sv
// Shared types, constants and helpers for the reachability closure block.
package rtc_pkg;

   // Largest level count the design supports, and the row slots of the store.
   localparam int MAX_LEVELS = 32;
   localparam int ROW_SLOTS  = 32;
   localparam int LEVEL_CAP  = (MAX_LEVELS < ROW_SLOTS) ? MAX_LEVELS : ROW_SLOTS;

   // Index width of one level, width of the level_count register.
   localparam int IDX_W = $clog2(ROW_SLOTS);
   localparam int CNT_W = 6;

   // Configuration register indexes.
   localparam logic CSR_LEVEL_COUNT     = 1'b0;
   localparam logic CSR_TRANSITIVE_MODE = 1'b1;

   // Settings in force, as the sequencer sees them.
   typedef struct packed {
      logic [IDX_W-1:0]     last_idx;
      logic [ROW_SLOTS-1:0] mask;
      logic                 transitive;
   } cfg_type;

   // One reachability row handed to the output stage.
   typedef struct packed {
      logic                 valid;
      logic [IDX_W-1:0]     index;
      logic [ROW_SLOTS-1:0] bits;
      logic                 last;
   } row_push_type;

   // Identity row: the level reaches itself only.
   function automatic logic [ROW_SLOTS-1:0] identity_row(input logic [IDX_W-1:0] idx);
      identity_row = {{(ROW_SLOTS-1){1'b0}}, 1'b1} << idx;
   endfunction

endpackage

FILE: hw/rtl/rtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rtc_seq.sv
// Sequencer: edge loading, Warshall closure and row emission over one row RAM.
module rtc_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rtc_pkg::IDX_W-1:0]     req_from_level,
   input  logic [rtc_pkg::IDX_W-1:0]     req_to_level,
   input  logic                          req_has_edge,
   input  logic                          req_last_edge,
   input  rtc_pkg::cfg_type              cfg,
   input  logic                          out_free,
   output rtc_pkg::row_push_type         push
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_LOAD_WR  = 7'b0000010,
      ST_PIV_RD   = 7'b0000100,
      ST_PIV_CAP  = 7'b0001000,
      ST_ROW_WR   = 7'b0010000,
      ST_EMIT_RD  = 7'b0100000,
      ST_EMIT_OUT = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [rtc_pkg::IDX_W-1:0]      pivot_ff, pivot_in;
   logic [rtc_pkg::IDX_W-1:0]      row_ff, row_in;
   logic [rtc_pkg::ROW_SLOTS-1:0]  valid_ff;
   logic [rtc_pkg::IDX_W-1:0]      last_idx_ff;
   logic [rtc_pkg::ROW_SLOTS-1:0]  mask_ff;
   logic                           trans_ff;
   logic                           last_ff;
   logic [rtc_pkg::IDX_W-1:0]      to_ff;
   logic [rtc_pkg::ROW_SLOTS-1:0]  pivot_row_ff, pivot_row_in;
   logic [rtc_pkg::IDX_W-1:0]      rd_addr_ff;
   logic                           rd_valid_ff;

   logic                           ram_wr_en;
   logic [rtc_pkg::IDX_W-1:0]      ram_wr_addr;
   logic [rtc_pkg::ROW_SLOTS-1:0]  ram_wr_data;
   logic                           ram_rd_en;
   logic [rtc_pkg::IDX_W-1:0]      ram_rd_addr;
   logic [rtc_pkg::ROW_SLOTS-1:0]  ram_rd_data;
   logic [rtc_pkg::ROW_SLOTS-1:0]  row_val;
   logic                           clear_valid;
   logic                           accept;
   logic                           edge_ok;

   rtc_ram #(
      .WIDTH (rtc_pkg::ROW_SLOTS),
      .DEPTH (rtc_pkg::ROW_SLOTS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign edge_ok   = req_has_edge && (req_from_level <= cfg.last_idx)
                      && (req_to_level <= cfg.last_idx);

   // A row never written since the last clear reads as identity.
   assign row_val = rd_valid_ff ? ram_rd_data : rtc_pkg::identity_row(rd_addr_ff);

   always_comb begin
      state_in     = state_ff;
      pivot_in     = pivot_ff;
      row_in       = row_ff;
      pivot_row_in = pivot_row_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_addr_ff;
      ram_wr_data  = row_val;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = row_ff;
      clear_valid  = 1'b0;
      push         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            pivot_in = '0;
            row_in   = '0;
            if (req_valid) begin
               if (edge_ok) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_from_level;
                  state_in    = ST_LOAD_WR;
               end else if (req_last_edge) begin
                  state_in = cfg.transitive ? ST_PIV_RD : ST_EMIT_RD;
               end
            end
         end
         ST_LOAD_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = row_val | rtc_pkg::identity_row(to_ff);
            if (last_ff) begin
               state_in = trans_ff ? ST_PIV_RD : ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PIV_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pivot_ff;
            state_in    = ST_PIV_CAP;
         end
         ST_PIV_CAP: begin
            pivot_row_in = row_val & mask_ff;
            ram_rd_en    = 1'b1;
            ram_rd_addr  = row_ff;
            state_in     = ST_ROW_WR;
         end
         ST_ROW_WR: begin
            // merge the pivot row into every row that reaches the pivot
            if (row_val[pivot_ff]) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = row_val | pivot_row_ff;
            end
            if (row_ff == last_idx_ff) begin
               row_in = '0;
               if (pivot_ff == last_idx_ff) begin
                  pivot_in = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  pivot_in = pivot_ff + 1'b1;
                  state_in = ST_PIV_RD;
               end
            end else begin
               row_in      = row_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = row_ff + 1'b1;
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = row_ff;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               push.valid = 1'b1;
               push.index = row_ff;
               push.bits  = row_val & mask_ff;
               push.last  = (row_ff == last_idx_ff);
               if (row_ff == last_idx_ff) begin
                  row_in      = '0;
                  clear_valid = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  row_in      = row_ff + 1'b1;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = row_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pivot_ff <= '0;
         row_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pivot_ff <= pivot_in;
         row_ff   <= row_in;
         if (clear_valid) begin
            valid_ff <= '0;
         end else if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pivot_row_ff <= pivot_row_in;
      if (accept) begin
         last_idx_ff <= cfg.last_idx;
         mask_ff     <= cfg.mask;
         trans_ff    <= cfg.transitive;
         last_ff     <= req_last_edge;
         to_ff       <= req_to_level;
      end
      if (ram_rd_en) begin
         rd_addr_ff  <= ram_rd_addr;
         rd_valid_ff <= valid_ff[ram_rd_addr];
      end
   end

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("row RAM read and write hit the same row");

   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (row_ff <= last_idx_ff))
      else $error("row pushed beyond the level count");

   a_pivot_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (pivot_ff <= last_idx_ff))
      else $error("pivot beyond the level count");

   a_store_back_to_identity: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.last) |=> (valid_ff == '0) && (state_ff == ST_IDLE))
      else $error("store not returned to identity after the final row");

endmodule

FILE: hw/rtl/reachability_transitive_closure_top.sv
// Top level: configuration registers, sequencer and result output register.
//
//   channel  ports                                        direction  handshake
//   req      req_from_level/to_level/has_edge/last_edge   in         req_valid / req_stall
//   rsp      rsp_row_index/row_bits/last_row              out        rsp_valid / rsp_stall
//   csr      csr_index, csr_write_data                    in         csr_write_enable
//
// An item with an in-range edge does a read-modify-write of one row through the row
// RAM; an item without one is taken without touching the RAM. A last item then runs
// the closure (per pivot: one pivot read, one capture, one read-merge-write per row)
// when transitive_mode is set, then emits n rows, waiting whenever rsp_stall holds
// the output register full; n is the clamped level count.
// Reset is synchronous; it clears control state and all row valid bits, so every
// row reads as identity. rsp_stall holds the output register and, while it is full,
// the row emission; the next item is taken while the final row still waits there.
module reachability_transitive_closure_top (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rtc_pkg::IDX_W-1:0]       req_from_level,
   input  logic [rtc_pkg::IDX_W-1:0]       req_to_level,
   input  logic                            req_has_edge,
   input  logic                            req_last_edge,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rtc_pkg::IDX_W-1:0]       rsp_row_index,
   output logic [rtc_pkg::ROW_SLOTS-1:0]   rsp_row_bits,
   output logic                            rsp_last_row,

   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [rtc_pkg::CNT_W-1:0]       csr_write_data
);

   logic [rtc_pkg::CNT_W-1:0]      level_count_ff;
   logic                           transitive_ff;
   logic [rtc_pkg::CNT_W-1:0]      levels;
   rtc_pkg::cfg_type               cfg;
   rtc_pkg::row_push_type          push;
   logic                           out_free;

   logic                           rsp_valid_ff;
   logic [rtc_pkg::IDX_W-1:0]      rsp_index_ff;
   logic [rtc_pkg::ROW_SLOTS-1:0]  rsp_bits_ff;
   logic                           rsp_last_ff;

   // Configuration: the user must write it only while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= rtc_pkg::CNT_W'(32);
         transitive_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rtc_pkg::CSR_LEVEL_COUNT:     level_count_ff <= csr_write_data;
            rtc_pkg::CSR_TRANSITIVE_MODE: transitive_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the level count to 1..cap and derive the last index and row mask.
   always_comb begin
      if (level_count_ff == '0) begin
         levels = rtc_pkg::CNT_W'(1);
      end else if (level_count_ff > rtc_pkg::CNT_W'(rtc_pkg::LEVEL_CAP)) begin
         levels = rtc_pkg::CNT_W'(rtc_pkg::LEVEL_CAP);
      end else begin
         levels = level_count_ff;
      end
      cfg.last_idx   = rtc_pkg::IDX_W'(levels - 1'b1);
      cfg.mask       = ~({rtc_pkg::ROW_SLOTS{1'b1}} << levels);
      cfg.transitive = transitive_ff;
   end

   rtc_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_from_level (req_from_level),
      .req_to_level   (req_to_level),
      .req_has_edge   (req_has_edge),
      .req_last_edge  (req_last_edge),
      .cfg            (cfg),
      .out_free       (out_free),
      .push           (push)
   );

   // Output register: load when empty or when the held row leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_index_ff <= push.index;
         rsp_bits_ff  <= push.bits;
         rsp_last_ff  <= push.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_index_ff;
   assign rsp_row_bits  = rsp_bits_ff;
   assign rsp_last_row  = rsp_last_ff;

endmodule

FILE: verif/reachability_transitive_closure_checker.sv
// Checker for the reachability closure block: mirrors the policy store and compares each row.
`timescale 1ns / 1ps

module reachability_transitive_closure_checker (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [rtc_pkg::IDX_W-1:0]     req_from_level,
   input  logic [rtc_pkg::IDX_W-1:0]     req_to_level,
   input  logic                          req_has_edge,
   input  logic                          req_last_edge,

   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [rtc_pkg::IDX_W-1:0]     rsp_row_index,
   input  logic [rtc_pkg::ROW_SLOTS-1:0] rsp_row_bits,
   input  logic                          rsp_last_row,

   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [rtc_pkg::CNT_W-1:0]     csr_write_data,

   output int                            mismatch_count,
   output int                            rows_outstanding
);

   typedef struct packed {
      logic [rtc_pkg::IDX_W-1:0]     index;
      logic [rtc_pkg::ROW_SLOTS-1:0] bits;
      logic                          last;
   } reach_row_type;

   logic [rtc_pkg::ROW_SLOTS-1:0] policy_rows [rtc_pkg::ROW_SLOTS];
   logic [rtc_pkg::CNT_W-1:0]     level_count_q;
   logic                          transitive_q;
   reach_row_type                 expected_rows [$];

   function automatic int levels_in_use(input logic [rtc_pkg::CNT_W-1:0] count_value);
      if (count_value == 0) return 1;
      if (count_value > rtc_pkg::LEVEL_CAP) return rtc_pkg::LEVEL_CAP;
      return int'(count_value);
   endfunction

   task automatic load_identity_rows();
      for (int i = 0; i < rtc_pkg::ROW_SLOTS; i++) begin
         policy_rows[i] = {{(rtc_pkg::ROW_SLOTS-1){1'b0}}, 1'b1} << i;
      end
   endtask

   // Record the edge, and on the last item close (in transitive mode), queue the rows, and reload identity.
   task automatic absorb_policy_item(input logic [rtc_pkg::IDX_W-1:0] src,
                                     input logic [rtc_pkg::IDX_W-1:0] dst,
                                     input logic has_edge, input logic last_edge);
      int                            n;
      logic [rtc_pkg::ROW_SLOTS-1:0] mask;
      logic [rtc_pkg::ROW_SLOTS-1:0] pivot_row;
      reach_row_type                 row;
      n    = levels_in_use(level_count_q);
      mask = {rtc_pkg::ROW_SLOTS{1'b1}} >> (rtc_pkg::ROW_SLOTS - n);
      if (has_edge && int'(src) < n && int'(dst) < n) begin
         policy_rows[src][dst] = 1'b1;
      end
      if (last_edge) begin
         if (transitive_q) begin
            for (int k = 0; k < n; k++) begin
               pivot_row = policy_rows[k] & mask;
               for (int i = 0; i < n; i++) begin
                  if (policy_rows[i][k]) policy_rows[i] = policy_rows[i] | pivot_row;
               end
            end
         end
         for (int i = 0; i < n; i++) begin
            row.index = rtc_pkg::IDX_W'(i);
            row.bits  = policy_rows[i] & mask;
            row.last  = (i == n - 1);
            expected_rows.push_back(row);
         end
         load_identity_rows();
      end
   endtask

   task automatic check_row();
      reach_row_type want;
      if (expected_rows.size() == 0) begin
         $error("row with nothing expected: row_index %0d row_bits %h last_row %0b",
                rsp_row_index, rsp_row_bits, rsp_last_row);
         mismatch_count++;
      end else begin
         want = expected_rows.pop_front();
         if (rsp_row_index !== want.index) begin
            $error("row_index: expected %0d, actual %0d", want.index, rsp_row_index);
            mismatch_count++;
         end
         if (rsp_row_bits !== want.bits) begin
            $error("row_bits: expected %h, actual %h", want.bits, rsp_row_bits);
            mismatch_count++;
         end
         if (rsp_last_row !== want.last) begin
            $error("last_row: expected %0b, actual %0b", want.last, rsp_last_row);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_identity_rows();
         level_count_q = rtc_pkg::CNT_W'(32);
         transitive_q  = 1'b1;
         expected_rows.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == rtc_pkg::CSR_LEVEL_COUNT) level_count_q = csr_write_data;
            else if (csr_index == rtc_pkg::CSR_TRANSITIVE_MODE) transitive_q = csr_write_data[0];
         end
         // Rows leaving now belong to an earlier policy: compare before queuing new ones.
         if (rsp_valid && !rsp_stall) check_row();
         if (req_valid && !req_stall) begin
            absorb_policy_item(req_from_level, req_to_level, req_has_edge, req_last_edge);
         end
      end
      rows_outstanding = expected_rows.size();
   end

endmodule

FILE: verif/tb_reachability_transitive_closure_top.sv
// Testbench top: drives edge items and register writes into the closure block and gives the verdict.
`timescale 1ns / 1ps

module tb_reachability_transitive_closure_top;

   // Quiet cycles allowed: a full 32-level closure runs with no handshake on either channel.
   localparam int WATCHDOG_LIMIT = 20000;
   // Cycles to let an edge read-modify-write finish before touching a register.
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 40;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [rtc_pkg::IDX_W-1:0]     req_from_level   = '0;
   logic [rtc_pkg::IDX_W-1:0]     req_to_level     = '0;
   logic                          req_has_edge     = 1'b0;
   logic                          req_last_edge    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [rtc_pkg::IDX_W-1:0]     rsp_row_index;
   logic [rtc_pkg::ROW_SLOTS-1:0] rsp_row_bits;
   logic                          rsp_last_row;
   logic                          csr_write_enable = 1'b0;
   logic                          csr_index        = rtc_pkg::CSR_LEVEL_COUNT;
   logic [rtc_pkg::CNT_W-1:0]     csr_write_data   = '0;

   int mismatch_count;
   int rows_outstanding;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int counted_items      = 0;

   reachability_transitive_closure_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_from_level   (req_from_level),
      .req_to_level     (req_to_level),
      .req_has_edge     (req_has_edge),
      .req_last_edge    (req_last_edge),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_row_bits     (rsp_row_bits),
      .rsp_last_row     (rsp_last_row),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   reachability_transitive_closure_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_from_level   (req_from_level),
      .req_to_level     (req_to_level),
      .req_has_edge     (req_has_edge),
      .req_last_edge    (req_last_edge),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_row_bits     (rsp_row_bits),
      .rsp_last_row     (rsp_last_row),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .rows_outstanding (rows_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure: redraw the stall at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Watchdog: end the run when no item moves on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("reachability_transitive_closure_top regression: fail");
      $finish;
   end

   function automatic int levels_in_use(input logic [rtc_pkg::CNT_W-1:0] count_value);
      if (count_value == 0) return 1;
      if (count_value > rtc_pkg::LEVEL_CAP) return rtc_pkg::LEVEL_CAP;
      return int'(count_value);
   endfunction

   // Mostly small policies; the full 32 levels and the clamped codes now and then.
   function automatic logic [rtc_pkg::CNT_W-1:0] pick_level_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return rtc_pkg::CNT_W'($urandom_range(1, 8));
      if (roll < 84) return rtc_pkg::CNT_W'($urandom_range(9, 31));
      if (roll < 91) return rtc_pkg::CNT_W'(32);
      if (roll < 94) return rtc_pkg::CNT_W'(0);
      return rtc_pkg::CNT_W'($urandom_range(33, 63));
   endfunction

   // Present one item from a falling edge and hold it until the block takes it.
   // Valid stays high into the next call, so back-to-back items never glitch it.
   task automatic send_item(input logic [rtc_pkg::IDX_W-1:0] src,
                            input logic [rtc_pkg::IDX_W-1:0] dst,
                            input logic has_edge, input logic last_edge);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_from_level = src;
      req_to_level   = dst;
      req_has_edge   = has_edge;
      req_last_edge  = last_edge;
      req_valid      = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, wait for every expected row, then let the block finish any edge update.
   task automatic settle();
      req_valid = 1'b0;
      while (rows_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [rtc_pkg::CNT_W-1:0] value);
      csr_index        = index;
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One random policy: fresh settings, a run of items, sometimes a count change midway.
   task automatic run_random_policy();
      logic [rtc_pkg::CNT_W-1:0] count_value;
      logic                      transitive;
      logic [rtc_pkg::IDX_W-1:0] src;
      logic [rtc_pkg::IDX_W-1:0] dst;
      logic                      has_edge;
      logic                      last_edge;
      int                        n;
      int                        item_total;
      int                        split_at;
      int                        roll;
      count_value = pick_level_count();
      transitive  = ($urandom_range(0, 3) != 0);
      settle();
      write_reg(rtc_pkg::CSR_LEVEL_COUNT, count_value);
      write_reg(rtc_pkg::CSR_TRANSITIVE_MODE,
                {(rtc_pkg::CNT_W-1)'($urandom_range(0, 31)), transitive});
      n          = levels_in_use(count_value);
      item_total = $urandom_range(1, 12);
      split_at   = (item_total > 1 && $urandom_range(0, 4) == 0) ?
                   $urandom_range(1, item_total - 1) : 0;
      for (int idx = 0; idx < item_total; idx++) begin
         if (split_at != 0 && idx == split_at) begin
            // Change the level count between items of the same policy.
            settle();
            count_value = pick_level_count();
            write_reg(rtc_pkg::CSR_LEVEL_COUNT, count_value);
            n = levels_in_use(count_value);
         end
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            src      = rtc_pkg::IDX_W'($urandom_range(0, n - 1));
            dst      = rtc_pkg::IDX_W'($urandom_range(0, n - 1));
            has_edge = 1'b1;
         end else begin
            // Noise: empty items and edges that may fall outside the levels in use.
            src      = rtc_pkg::IDX_W'($urandom_range(0, 31));
            dst      = rtc_pkg::IDX_W'($urandom_range(0, 31));
            has_edge = (roll >= 90);
         end
         last_edge = (idx == item_total - 1);
         send_item(src, dst, has_edge, last_edge);
         counted_items++;
      end
   endtask

   initial begin
      int items_goal;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: 32 levels, closure on. Chain across the extremes, an empty item,
      // and an edge riding on the last item.
      send_item(5'd0,  5'd1,  1'b1, 1'b0);
      send_item(5'd1,  5'd2,  1'b1, 1'b0);
      send_item(5'd31, 5'd0,  1'b1, 1'b0);
      send_item(5'd30, 5'd31, 1'b1, 1'b0);
      send_item(5'd5,  5'd5,  1'b0, 1'b0);
      send_item(5'd2,  5'd30, 1'b1, 1'b1);

      // Closure off: rows come out as loaded, ended by an empty last item.
      settle();
      write_reg(rtc_pkg::CSR_TRANSITIVE_MODE, rtc_pkg::CNT_W'(0));
      send_item(5'd3, 5'd7, 1'b1, 1'b0);
      send_item(5'd7, 5'd9, 1'b1, 1'b0);
      send_item(5'd0, 5'd0, 1'b0, 1'b1);

      // One level in use: out-of-range edges are dropped.
      settle();
      write_reg(rtc_pkg::CSR_LEVEL_COUNT, rtc_pkg::CNT_W'(1));
      write_reg(rtc_pkg::CSR_TRANSITIVE_MODE, rtc_pkg::CNT_W'(1));
      send_item(5'd0,  5'd0,  1'b1, 1'b0);
      send_item(5'd0,  5'd5,  1'b1, 1'b0);
      send_item(5'd31, 5'd31, 1'b1, 1'b1);

      // A count of zero acts as one level.
      settle();
      write_reg(rtc_pkg::CSR_LEVEL_COUNT, rtc_pkg::CNT_W'(0));
      send_item(5'd0, 5'd0, 1'b0, 1'b1);

      // Count above the cap, then lowered mid-policy: stale high bits must be masked.
      settle();
      write_reg(rtc_pkg::CSR_LEVEL_COUNT, rtc_pkg::CNT_W'(63));
      send_item(5'd31, 5'd30, 1'b1, 1'b0);
      send_item(5'd30, 5'd1,  1'b1, 1'b0);
      send_item(5'd1,  5'd30, 1'b1, 1'b0);
      settle();
      write_reg(rtc_pkg::CSR_LEVEL_COUNT, rtc_pkg::CNT_W'(4));
      send_item(5'd1, 5'd3, 1'b1, 1'b0);
      send_item(5'd3, 5'd2, 1'b1, 1'b1);

      // Smallest closing pair: a two-level cycle.
      settle();
      write_reg(rtc_pkg::CSR_LEVEL_COUNT, rtc_pkg::CNT_W'(2));
      send_item(5'd1, 5'd0, 1'b1, 1'b0);
      send_item(5'd0, 5'd1, 1'b1, 1'b1);

      // Random policies under each idling pattern in turn.
      for (int phase_sel = 0; phase_sel < 4; phase_sel++) begin
         case (phase_sel)
            0: begin
               sender_idle_pct = 0;  receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 52; receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;  receiver_stall_pct = 52;
            end
            default: begin
               sender_idle_pct = 16; receiver_stall_pct = 16;
            end
         endcase
         items_goal = counted_items + 80;
         while (counted_items < items_goal) run_random_policy();
      end

      // Drain: wait out every expected row, then a few more cycles for strays.
      req_valid = 1'b0;
      while (rows_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("reachability_transitive_closure_top regression: pass");
      end else begin
         $display("reachability_transitive_closure_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_ram.sv
hw/rtl/rtc_seq.sv
hw/rtl/reachability_transitive_closure_top.sv
verif/reachability_transitive_closure_checker.sv
verif/tb_reachability_transitive_closure_top.sv
